// ----- rtl/core/lrd_pkg.sv -----
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and codes of the lift request dispatcher.
// ----------------------------------------------------------------------------
package lrd_pkg;

   // operation codes of a request transaction
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_PLACE = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_ACCEPT  = 3'd0;
   localparam logic [2:0] KIND_INVALID = 3'd1;
   localparam logic [2:0] KIND_FULL    = 3'd2;
   localparam logic [2:0] KIND_ASSIGN  = 3'd3;
   localparam logic [2:0] KIND_EMPTY   = 3'd4;
   localparam logic [2:0] KIND_PLACED  = 3'd5;

   // two-bit signed directions
   localparam logic signed [1:0] DIR_UP   = 2'sb01;
   localparam logic signed [1:0] DIR_DOWN = 2'sb11;
   localparam logic signed [1:0] DIR_NONE = 2'sb00;

   localparam logic [3:0] PENALTY_RESET = 4'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_READ,
      ST_SCAN,
      ST_ASSIGN
   } state_type;

   typedef struct packed {
      logic take;
      logic q_read;
      logic scan_en;
      logic single;
      logic assign_call;
   } dp_cmd_type;

   typedef struct packed {
      logic run_go;
      logic scan_last;
      logic call_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/core/lrd_req_if.sv -----
// ----------------------------------------------------------------------------
// lrd_req_if
// Request channel: operation, floor, direction and lift index.
// ----------------------------------------------------------------------------
interface lrd_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [3:0]        floor;
   logic signed [1:0] dir;
   logic [3:0]        lift_index;

   modport source (output valid, output op, output floor, output dir, output lift_index,
                   input ready);
   modport sink   (input valid, input op, input floor, input dir, input lift_index,
                   output ready);
endinterface

// ----- rtl/core/lrd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lrd_rsp_if
// Result channel: kind of result and assignment details.
// ----------------------------------------------------------------------------
interface lrd_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic [3:0]        assigned_lift;
   logic [3:0]        call_floor;
   logic signed [1:0] call_dir;
   logic signed [1:0] move_dir;
   logic [4:0]        cost;
   logic              last;

   modport source (output valid, output kind, output assigned_lift, output call_floor,
                   output call_dir, output move_dir, output cost, output last,
                   input ready);
   modport sink   (input valid, input kind, input assigned_lift, input call_floor,
                   input call_dir, input move_dir, input cost, input last,
                   output ready);
endinterface

// ----- rtl/core/lrd_csr_if.sv -----
// ----------------------------------------------------------------------------
// lrd_csr_if
// Register write channel carrying the direction penalty.
// ----------------------------------------------------------------------------
interface lrd_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/lift_request_dispatcher.sv -----
// ----------------------------------------------------------------------------
// lift_request_dispatcher
// Nearest-car hall call dispatcher with a call queue and a bank of lifts.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time. Add, place and invalid or
// empty-run requests give one result, loaded into the result register once
// it is free. A run gives one assignment per queued call, each through a
// queue memory read, a scan of every lift in turn through the shared cost
// compare, and a step that moves the winning lift and loads the result
// register; a stalled result port holds that step. The next request is taken
// in the cycle after the last result of a transaction is loaded, while that
// result may still wait on the result port. The penalty register accepts writes
// at any time but must only be written while no request is in flight.
module lift_request_dispatcher #(
   parameter int LIFTS       = 10,
   parameter int QUEUE_DEPTH = 32,
   parameter int FLOORS      = 10
) (
   input logic      clock,
   input logic      reset,
   lrd_req_if.sink  req,
   lrd_rsp_if.source rsp,
   lrd_csr_if.sink  csr
);
   import lrd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ctrl_req_ready;

   assign req.ready = ctrl_req_ready;
   assign csr.ready = 1'b1;

   lrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctrl_req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrd_dpath #(
      .LIFTS       (LIFTS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .FLOORS      (FLOORS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req.op),
      .req_floor         (req.floor),
      .req_dir           (req.dir),
      .req_lift_index    (req.lift_index),
      .csr_valid         (csr.valid),
      .csr_data          (csr.data),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_kind          (rsp.kind),
      .rsp_assigned_lift (rsp.assigned_lift),
      .rsp_call_floor    (rsp.call_floor),
      .rsp_call_dir      (rsp.call_dir),
      .rsp_move_dir      (rsp.move_dir),
      .rsp_cost          (rsp.cost),
      .rsp_last          (rsp.last),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ----- rtl/core/lrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrd_ctrl
// Sequencer: accepts a transaction, steps a dispatch run through queue
// reads, lift scans and assignments.
// ----------------------------------------------------------------------------
module lrd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lrd_pkg::dp_status_type status,
   output lrd_pkg::dp_cmd_type    cmd
);
   import lrd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.run_go ? ST_READ : ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_ASSIGN;
            end
         end
         ST_ASSIGN: begin
            if (status.out_free) begin
               state_in = status.call_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_SINGLE: begin
            cmd.single = status.out_free;
         end
         ST_READ: begin
            cmd.q_read = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
         end
         ST_ASSIGN: begin
            cmd.assign_call = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/core/lrd_dpath.sv -----
// ----------------------------------------------------------------------------
// lrd_dpath
// Datapath: call queue memory, lift floors and directions, least-cost
// scan, penalty register and the result register.
// ----------------------------------------------------------------------------
module lrd_dpath #(
   parameter int LIFTS       = 10,
   parameter int QUEUE_DEPTH = 32,
   parameter int FLOORS      = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_op,
   input  logic [3:0]             req_floor,
   input  logic signed [1:0]      req_dir,
   input  logic [3:0]             req_lift_index,
   input  logic                   csr_valid,
   input  logic [3:0]             csr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_kind,
   output logic [3:0]             rsp_assigned_lift,
   output logic [3:0]             rsp_call_floor,
   output logic signed [1:0]      rsp_call_dir,
   output logic signed [1:0]      rsp_move_dir,
   output logic [4:0]             rsp_cost,
   output logic                   rsp_last,
   input  lrd_pkg::dp_cmd_type    cmd,
   output lrd_pkg::dp_status_type status
);
   import lrd_pkg::*;

   localparam int LA_W   = (LIFTS > 1) ? $clog2(LIFTS) : 1;
   localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [3:0]        pen_ff;

   logic [1:0]        in_op_ff;
   logic [3:0]        in_floor_ff;
   logic signed [1:0] in_dir_ff;
   logic [3:0]        in_lift_ff;

   logic [3:0]        lift_floor_ff [LIFTS];
   logic signed [1:0] lift_dir_ff   [LIFTS];

   logic [3:0]        q_floor_mem [QUEUE_DEPTH];
   logic              q_up_mem    [QUEUE_DEPTH];
   logic [3:0]        q_floor_rd_ff;
   logic              q_up_rd_ff;

   logic [FILL_W-1:0] fill_ff;
   logic [QA_W-1:0]   rd_ptr_ff;

   logic [LA_W-1:0]   scan_ff;
   logic [LA_W-1:0]   best_ff;
   logic [4:0]        best_cost_ff;
   logic [3:0]        best_floor_ff;

   logic              rsp_valid_ff;
   logic [2:0]        kind_ff;
   logic [3:0]        lift_out_ff;
   logic [3:0]        floor_out_ff;
   logic signed [1:0] cdir_out_ff;
   logic signed [1:0] mdir_out_ff;
   logic [4:0]        cost_out_ff;
   logic              last_out_ff;

   logic              floor_ok;
   logic              dir_ok;
   logic              full;
   logic              q_we;
   logic              place_we;
   logic [2:0]        single_kind;
   logic signed [1:0] call_dir;
   logic [3:0]        scan_floor;
   logic signed [1:0] scan_dir;
   logic [3:0]        floor_gap;
   logic [4:0]        scan_cost;
   logic signed [1:0] move_dir;
   logic              out_free;
   logic              call_last;

   // penalty register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= PENALTY_RESET;
      end else if (csr_valid) begin
         pen_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         in_op_ff    <= req_op;
         in_floor_ff <= req_floor;
         in_dir_ff   <= req_dir;
         in_lift_ff  <= req_lift_index;
      end
   end

   // single-result decode
   assign floor_ok = (in_floor_ff >= 4'd1) && (in_floor_ff <= 4'(FLOORS));
   assign dir_ok   = (in_dir_ff == DIR_UP) || (in_dir_ff == DIR_DOWN);
   assign full     = (fill_ff == FILL_W'(QUEUE_DEPTH));

   always_comb begin
      single_kind = KIND_INVALID;
      unique case (in_op_ff)
         OP_ADD: begin
            if (!floor_ok || !dir_ok) begin
               single_kind = KIND_INVALID;
            end else if (full) begin
               single_kind = KIND_FULL;
            end else begin
               single_kind = KIND_ACCEPT;
            end
         end
         OP_RUN: begin
            single_kind = KIND_EMPTY;
         end
         OP_PLACE: begin
            if (floor_ok && ({1'b0, in_lift_ff} < 5'(LIFTS))) begin
               single_kind = KIND_PLACED;
            end else begin
               single_kind = KIND_INVALID;
            end
         end
         default: begin
            single_kind = KIND_INVALID;
         end
      endcase
   end

   assign q_we     = cmd.single && (single_kind == KIND_ACCEPT);
   assign place_we = cmd.single && (single_kind == KIND_PLACED);

   // call queue
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_floor_mem[fill_ff[QA_W-1:0]] <= in_floor_ff;
         q_up_mem[fill_ff[QA_W-1:0]]    <= (in_dir_ff == DIR_UP);
      end
      if (cmd.q_read) begin
         q_floor_rd_ff <= q_floor_mem[rd_ptr_ff];
         q_up_rd_ff    <= q_up_mem[rd_ptr_ff];
      end
   end

   assign call_last = ((FILL_W'(rd_ptr_ff) + FILL_W'(1)) == fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (q_we) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (cmd.assign_call && call_last) begin
            fill_ff <= '0;
         end
         if (cmd.assign_call) begin
            rd_ptr_ff <= call_last ? '0 : rd_ptr_ff + QA_W'(1);
         end
      end
   end

   // least-cost scan, one lift per cycle
   assign call_dir   = q_up_rd_ff ? DIR_UP : DIR_DOWN;
   assign scan_floor = lift_floor_ff[scan_ff];
   assign scan_dir   = lift_dir_ff[scan_ff];
   assign floor_gap  = (scan_floor > q_floor_rd_ff) ? scan_floor - q_floor_rd_ff
                                                    : q_floor_rd_ff - scan_floor;
   assign scan_cost  = 5'(floor_gap) +
                       (((scan_dir != DIR_NONE) && (scan_dir != call_dir)) ? 5'(pen_ff)
                                                                           : 5'd0);

   always_ff @(posedge clock) begin
      if (cmd.q_read) begin
         scan_ff <= '0;
      end else if (cmd.scan_en) begin
         scan_ff <= scan_ff + LA_W'(1);
         // strict compare keeps the lowest index on a tie
         if ((scan_ff == '0) || (scan_cost < best_cost_ff)) begin
            best_ff       <= scan_ff;
            best_cost_ff  <= scan_cost;
            best_floor_ff <= scan_floor;
         end
      end
   end

   always_comb begin
      if (best_floor_ff < q_floor_rd_ff) begin
         move_dir = DIR_UP;
      end else if (best_floor_ff > q_floor_rd_ff) begin
         move_dir = DIR_DOWN;
      end else begin
         move_dir = DIR_NONE;
      end
   end

   // lift bank
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIFTS; i++) begin
            lift_floor_ff[i] <= 4'd1;
            lift_dir_ff[i]   <= DIR_NONE;
         end
      end else if (cmd.assign_call) begin
         lift_floor_ff[best_ff] <= q_floor_rd_ff;
         lift_dir_ff[best_ff]   <= move_dir;
      end else if (place_we) begin
         lift_floor_ff[in_lift_ff[LA_W-1:0]] <= in_floor_ff;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.single || cmd.assign_call) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.assign_call) begin
         kind_ff      <= KIND_ASSIGN;
         lift_out_ff  <= 4'(best_ff);
         floor_out_ff <= q_floor_rd_ff;
         cdir_out_ff  <= call_dir;
         mdir_out_ff  <= move_dir;
         cost_out_ff  <= best_cost_ff;
         last_out_ff  <= call_last;
      end else if (cmd.single) begin
         kind_ff      <= single_kind;
         lift_out_ff  <= '0;
         floor_out_ff <= '0;
         cdir_out_ff  <= DIR_NONE;
         mdir_out_ff  <= DIR_NONE;
         cost_out_ff  <= '0;
         last_out_ff  <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_assigned_lift = lift_out_ff;
   assign rsp_call_floor    = floor_out_ff;
   assign rsp_call_dir      = cdir_out_ff;
   assign rsp_move_dir      = mdir_out_ff;
   assign rsp_cost          = cost_out_ff;
   assign rsp_last          = last_out_ff;

   assign status.run_go    = (req_op == OP_RUN) && (fill_ff != '0);
   assign status.scan_last = (scan_ff == LA_W'(LIFTS - 1));
   assign status.call_last = call_last;
   assign status.out_free  = out_free;

endmodule

// ----- rtl/core/lrd_checker.sv -----
// ----------------------------------------------------------------------------
// lrd_checker
// Port-level checks of the lift request dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module lrd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_kind,
   input logic [3:0]        rsp_assigned_lift,
   input logic [3:0]        rsp_call_floor,
   input logic signed [1:0] rsp_move_dir,
   input logic [4:0]        rsp_cost,
   input logic              rsp_last
);
   import lrd_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_cost))
      else $error("result changed while stalled");

   // only runs produce more than one result
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_ASSIGN) |-> rsp_last)
      else $error("non-assignment result without last");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_ASSIGN) |->
         (rsp_cost == 5'd0) && (rsp_assigned_lift == 4'd0) &&
         (rsp_call_floor == 4'd0) && (rsp_move_dir == DIR_NONE))
      else $error("non-assignment result with nonzero fields");

   // one transaction in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind lift_request_dispatcher lrd_checker u_lrd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_kind          (rsp.kind),
   .rsp_assigned_lift (rsp.assigned_lift),
   .rsp_call_floor    (rsp.call_floor),
   .rsp_move_dir      (rsp.move_dir),
   .rsp_cost          (rsp.cost),
   .rsp_last          (rsp.last)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lift request dispatcher.
// ----------------------------------------------------------------------------
// Hall calls, runs and lift placements are queued by a stimulus process and
// driven into the request channel with random gaps. Every request transaction
// is run through a cycle-free model of the dispatcher (call queue, lift
// floors and directions, direction penalty). The model lists the results that
// the request must give, and each result transaction is compared against the
// oldest listed one. The penalty register is rewritten between phases while
// the block is idle, and the flow control on both channels varies by phase.
// ----------------------------------------------------------------------------
module tb_top;
   import lrd_pkg::*;

   localparam int LIFTS         = 10;
   localparam int QUEUE_DEPTH   = 32;
   localparam int FLOORS        = 10;
   localparam int SETTLE_CYCLES = 2 * (LIFTS + 2);
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [1:0]        OP_UNUSED = 2'd3;
   localparam logic signed [1:0] DIR_BAD   = 2'sb10;

   typedef struct {
      logic [1:0]        op;
      logic [3:0]        floor;
      logic signed [1:0] dir;
      logic [3:0]        lift_index;
   } hall_item_type;

   typedef struct {
      logic [2:0]        kind;
      logic [3:0]        assigned_lift;
      logic [3:0]        call_floor;
      logic signed [1:0] call_dir;
      logic signed [1:0] move_dir;
      logic [4:0]        cost;
      logic              last;
   } outcome_type;

   logic clock;
   logic reset;

   lrd_req_if req_ch ();
   lrd_rsp_if rsp_ch ();
   lrd_csr_if csr_ch ();

   lift_request_dispatcher #(
      .LIFTS       (LIFTS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .FLOORS      (FLOORS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // pending request items and results still owed by the block
   hall_item_type hall_items[$];
   outcome_type   call_outcomes[$];

   // model state
   logic [3:0]        car_floor [LIFTS];
   logic signed [1:0] car_dir [LIFTS];
   logic [3:0]        call_floor_q [QUEUE_DEPTH];
   logic              call_up_q [QUEUE_DEPTH];
   int                calls_waiting;
   logic [3:0]        penalty;

   int   send_idle_pct = 22;
   int   recv_idle_pct = 64;
   logic req_taken;
   int   items_queued = 0;
   int   items_taken = 0;
   int   results_seen = 0;
   int   assignments_seen = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;
   logic [3:0] last_penalty;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic outcome_type plain_outcome(logic [2:0] kind);
      outcome_type o;
      o = '{kind, 4'd0, 4'd0, DIR_NONE, DIR_NONE, 5'd0, 1'b1};
      return o;
   endfunction

   // works out every result one request transaction must produce
   task automatic dispatch_outcomes(hall_item_type it);
      outcome_type       o;
      bit                floor_ok;
      int                k, i, lf, cf, c, best, best_cost;
      logic signed [1:0] cd, md;
      floor_ok = it.floor >= 1 && it.floor <= FLOORS;
      case (it.op)
         OP_ADD: begin
            if (!floor_ok || (it.dir != DIR_UP && it.dir != DIR_DOWN))
               call_outcomes.push_back(plain_outcome(KIND_INVALID));
            else if (calls_waiting >= QUEUE_DEPTH)
               call_outcomes.push_back(plain_outcome(KIND_FULL));
            else begin
               call_floor_q[calls_waiting] = it.floor;
               call_up_q[calls_waiting] = (it.dir == DIR_UP);
               calls_waiting++;
               call_outcomes.push_back(plain_outcome(KIND_ACCEPT));
            end
         end
         OP_RUN: begin
            if (calls_waiting == 0)
               call_outcomes.push_back(plain_outcome(KIND_EMPTY));
            else begin
               for (k = 0; k < calls_waiting; k++) begin
                  cf = call_floor_q[k];
                  cd = call_up_q[k] ? DIR_UP : DIR_DOWN;
                  best = 0;
                  best_cost = 0;
                  for (i = 0; i < LIFTS; i++) begin
                     lf = car_floor[i];
                     c = (lf > cf) ? lf - cf : cf - lf;
                     if (car_dir[i] != DIR_NONE && car_dir[i] != cd)
                        c += int'(penalty);
                     // strict compare keeps the lowest index on a tie
                     if (i == 0 || c < best_cost) begin
                        best = i;
                        best_cost = c;
                     end
                  end
                  lf = car_floor[best];
                  if (lf < cf)
                     md = DIR_UP;
                  else if (lf > cf)
                     md = DIR_DOWN;
                  else
                     md = DIR_NONE;
                  car_dir[best] = md;
                  car_floor[best] = 4'(cf);
                  o = plain_outcome(KIND_ASSIGN);
                  o.assigned_lift = 4'(best);
                  o.call_floor = 4'(cf);
                  o.call_dir = cd;
                  o.move_dir = md;
                  o.cost = 5'(best_cost);
                  o.last = (k == calls_waiting - 1);
                  call_outcomes.push_back(o);
               end
               calls_waiting = 0;
            end
         end
         OP_PLACE: begin
            if (!floor_ok || it.lift_index >= LIFTS)
               call_outcomes.push_back(plain_outcome(KIND_INVALID));
            else begin
               // direction is kept, only the floor moves
               car_floor[it.lift_index] = it.floor;
               call_outcomes.push_back(plain_outcome(KIND_PLACED));
            end
         end
         default: call_outcomes.push_back(plain_outcome(KIND_INVALID));
      endcase
   endtask

   // request driver
   always @(negedge clock) begin : driver
      hall_item_type next_item;
      if (!req_ch.valid || req_taken) begin
         if (hall_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = hall_items.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.op <= next_item.op;
            req_ch.floor <= next_item.floor;
            req_ch.dir <= next_item.dir;
            req_ch.lift_index <= next_item.lift_index;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: checks results, then feeds accepted requests to the model
   always @(posedge clock) begin : monitor
      outcome_type   want;
      hall_item_type taken;
      if (reset) begin
         for (int n = 0; n < LIFTS; n++) begin
            car_floor[n] = 4'd1;
            car_dir[n] = DIR_NONE;
         end
         calls_waiting = 0;
         penalty = PENALTY_RESET;
         req_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.kind == KIND_ASSIGN)
               assignments_seen++;
            if (call_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result transaction: kind %0d lift %0d cost %0d",
                           rsp_ch.kind, rsp_ch.assigned_lift, rsp_ch.cost);
            end else begin
               want = call_outcomes.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.assigned_lift !== want.assigned_lift ||
                   rsp_ch.call_floor !== want.call_floor || rsp_ch.call_dir !== want.call_dir ||
                   rsp_ch.move_dir !== want.move_dir || rsp_ch.cost !== want.cost ||
                   rsp_ch.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("result mismatch: expected kind %0d lift %0d floor %0d dir %0d",
                              want.kind, want.assigned_lift, want.call_floor, want.call_dir,
                              " move %0d cost %0d last %0d", want.move_dir, want.cost,
                              want.last);
                     $display("                 actual   kind %0d lift %0d floor %0d dir %0d",
                              rsp_ch.kind, rsp_ch.assigned_lift, rsp_ch.call_floor,
                              rsp_ch.call_dir, " move %0d cost %0d last %0d",
                              rsp_ch.move_dir, rsp_ch.cost, rsp_ch.last);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken = '{req_ch.op, req_ch.floor, req_ch.dir, req_ch.lift_index};
            dispatch_outcomes(taken);
            items_taken++;
         end
         if (csr_ch.valid && csr_ch.ready)
            penalty = csr_ch.data;
         req_taken <= req_ch.valid && req_ch.ready;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results still owed",
                  quiet_cycles, call_outcomes.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_item(logic [1:0] op, logic [3:0] floor, logic signed [1:0] dir,
                            logic [3:0] lift_index);
      hall_item_type it;
      it = '{op, floor, dir, lift_index};
      hall_items.push_back(it);
      items_queued++;
   endtask

   // mostly add bursts closed by a run, with placements and noise in between
   task automatic queue_random(int count);
      int target, burst;
      target = items_queued + count;
      while (items_queued < target) begin
         case ($urandom_range(9))
            0: push_item(2'($urandom), 4'($urandom), 2'($urandom), 4'($urandom));
            1: push_item(OP_PLACE, 4'($urandom_range(1, FLOORS + 1)), 2'($urandom),
                         4'($urandom_range(0, LIFTS)));
            default: begin
               burst = $urandom_range(1, 6);
               repeat (burst)
                  push_item(OP_ADD, 4'($urandom_range(1, FLOORS)),
                            $urandom_range(1) ? DIR_UP : DIR_DOWN, 4'($urandom));
               push_item(OP_RUN, 4'($urandom), 2'($urandom), 4'($urandom));
            end
         endcase
      end
   endtask

   // sender holds off until every queued item is taken and every result is in
   task automatic wait_drained();
      do
         @(negedge clock);
      while (items_taken != items_queued || call_outcomes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_penalty(logic [3:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      last_penalty = value;
   endtask

   initial begin : stimulus
      req_ch.valid = 1'b0;
      req_ch.op = OP_ADD;
      req_ch.floor = 4'd0;
      req_ch.dir = DIR_NONE;
      req_ch.lift_index = 4'd0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = 4'd0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, penalty at its reset value
      push_item(OP_RUN, 4'd0, DIR_NONE, 4'd0);      // run with nothing queued
      push_item(OP_ADD, 4'd0, DIR_UP, 4'd0);
      push_item(OP_ADD, 4'd15, DIR_DOWN, 4'd0);
      push_item(OP_ADD, 4'd11, DIR_UP, 4'd0);
      push_item(OP_ADD, 4'd5, DIR_NONE, 4'd0);
      push_item(OP_ADD, 4'd5, DIR_BAD, 4'd0);
      push_item(OP_UNUSED, 4'd15, DIR_BAD, 4'd15);
      push_item(OP_PLACE, 4'd10, DIR_NONE, 4'd9);
      push_item(OP_PLACE, 4'd1, DIR_NONE, 4'd10);
      push_item(OP_PLACE, 4'd0, DIR_NONE, 4'd0);
      push_item(OP_PLACE, 4'd15, DIR_NONE, 4'd15);
      push_item(OP_ADD, 4'd10, DIR_DOWN, 4'd0);     // lift already on the call floor
      push_item(OP_ADD, 4'd1, DIR_UP, 4'd0);
      push_item(OP_ADD, 4'd10, DIR_UP, 4'd0);
      push_item(OP_ADD, 4'd6, DIR_DOWN, 4'd0);
      push_item(OP_RUN, 4'd0, DIR_NONE, 4'd0);
      push_item(OP_PLACE, 4'd3, DIR_NONE, 4'd4);
      push_item(OP_PLACE, 4'd2, DIR_NONE, 4'd9);    // keeps its down direction
      push_item(OP_ADD, 4'd9, DIR_UP, 4'd0);        // opposing lift pays the penalty
      push_item(OP_ADD, 4'd3, DIR_UP, 4'd0);
      push_item(OP_RUN, 4'd0, DIR_NONE, 4'd0);
      wait_drained();

      write_penalty(4'd0);
      queue_random(25);
      wait_drained();

      send_idle_pct = 64;
      recv_idle_pct = 22;
      write_penalty(4'd15);
      // fill the call queue past its depth, then an invalid call while full
      repeat (QUEUE_DEPTH + 1)
         push_item(OP_ADD, 4'($urandom_range(1, FLOORS)),
                   $urandom_range(1) ? DIR_UP : DIR_DOWN, 4'($urandom));
      push_item(OP_ADD, 4'd0, DIR_UP, 4'd0);
      push_item(OP_RUN, 4'd0, DIR_NONE, 4'd0);
      queue_random(10);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_penalty(4'($urandom_range(1, 14)));
      queue_random(20);
      wait_drained();

      $display("covered %0d requests and %0d results, %0d of them lift assignments",
               items_taken, results_seen, assignments_seen);
      $display("penalty settings 5, 0, 15 and %0d; %0d mismatches", last_penalty, mismatches);
      if (mismatches == 0 && call_outcomes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
